>>> rtl/core/convex_polygon_unit_sphere_test_assert.svh
// Assertion helpers shared by the RTL of the polygon sphere test.
`ifndef CONVEX_POLYGON_UNIT_SPHERE_TEST_ASSERT_SVH
`define CONVEX_POLYGON_UNIT_SPHERE_TEST_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define CPUS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define CPUS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/core/cpus_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package cpus_pkg;

    localparam int OPW   = 36;
    localparam int ACC_W = 112;
    localparam int UNIT_SQ_SHIFT = 24;
    localparam logic signed [OPW-1:0] UNIT_SQ = 36'sd16777216;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_DEGEN  = 2'd1,
        ST_TOOMANY = 2'd2
    } t_status;

    typedef struct packed {
        logic signed [15:0] vertex_x;
        logic signed [15:0] vertex_y;
        logic signed [15:0] vertex_z;
        logic               last_vertex;
    } t_vtx;

    typedef struct packed {
        logic       hit;
        logic [1:0] status;
    } t_res;

    typedef enum logic [1:0] {
        SH_0  = 2'd0,
        SH_24 = 2'd1,
        SH_28 = 2'd2,
        SH_54 = 2'd3
    } t_shift;

    typedef struct packed {
        logic   en;
        logic   clr;
        logic   neg;
        t_shift sh;
    } t_mac_ctl;

    typedef enum logic [3:0] {
        S_LOAD, S_CHK, S_RD0, S_RD1, S_RD2, S_NRM, S_NZ, S_PLANE,
        S_ERD, S_ESUB, S_EDGE, S_WRD, S_WIND, S_EMIT
    } t_state;

    function automatic logic [1:0] nx(input logic [1:0] m);
        return (m == 2'd2) ? 2'd0 : m + 2'd1;
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/cpus_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface cpus_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/core/cpus_mac.sv
`timescale 1ns / 1ps
`default_nettype none
module cpus_mac (
    input  wire logic                                 i_clk,
    input  wire logic signed [cpus_pkg::OPW-1:0]      i_a,
    input  wire logic signed [cpus_pkg::OPW-1:0]      i_b,
    input  wire cpus_pkg::t_mac_ctl                   i_ctl,
    output logic signed [cpus_pkg::ACC_W-1:0]         o_acc
);
    import cpus_pkg::*;

    logic signed [2*OPW-1:0] prod;
    logic signed [ACC_W-1:0] ext;
    logic signed [ACC_W-1:0] term;
    logic signed [ACC_W-1:0] n_acc;
    logic signed [ACC_W-1:0] r_acc;

    assign prod = i_a * i_b;
    assign ext  = ACC_W'(prod);

    always_comb begin
        case (i_ctl.sh)
            SH_0:    term = ext;
            SH_24:   term = ext <<< 24;
            SH_28:   term = ext <<< 28;
            SH_54:   term = ext <<< 54;
            default: term = ext;
        endcase
        n_acc = (i_ctl.clr ? '0 : r_acc) + (i_ctl.neg ? -term : term);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_acc <= n_acc;
        end
    end

    assign o_acc = r_acc;
endmodule
`default_nettype wire

>>> rtl/core/convex_polygon_unit_sphere_test.sv
// Vertices are taken one per cycle while the unit is in its load state; the final vertex starts the test.
// The test runs a plane test, then one distance pass and one winding pass per
// edge, and ends early when the plane test or an edge settles the answer.
// One polygon at a time: input is held off while the shared multiplier works.
// Synchronous active-low reset clears control state and any pending result.
`timescale 1ns / 1ps
`default_nettype none
`include "convex_polygon_unit_sphere_test_assert.svh"
module convex_polygon_unit_sphere_test #(
    parameter int MAX_VERTICES = 8
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    cpus_stream_if.sink    i_vtx,
    cpus_stream_if.source  o_res
);
    import cpus_pkg::*;

    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW = $clog2(MAX_VERTICES + 1);

    t_state r_state, n_state;
    logic [4:0]    r_k, n_k;
    logic [AW-1:0] r_i, n_i;
    logic [CW-1:0] r_cnt;
    logic          r_ovr;
    logic          r_rhit, n_rhit;
    logic [1:0]    r_rst, n_rst;
    logic          r_ohit;
    logic [1:0]    r_ost;
    logic          r_ovalid;
    logic          emit_go;

    logic [47:0]   r_mem [MAX_VERTICES];
    logic [AW-1:0] addr_a, addr_b;
    logic          rd_en;
    logic signed [15:0] r_ra [3];
    logic signed [15:0] r_rb [3];
    logic signed [15:0] r_v0 [3];
    logic signed [16:0] r_d1 [3];
    logic signed [16:0] r_d2 [3];
    logic signed [16:0] r_e  [3];
    logic signed [34:0] r_n  [3];
    logic signed [33:0] r_c  [3];
    logic signed [52:0] r_p;
    logic signed [ACC_W-1:0] r_lim;
    logic signed [OPW-1:0]   r_elen;
    logic signed [OPW-1:0]   r_ae;
    logic signed [33:0]      r_aa, r_bb;

    logic signed [OPW-1:0]   mac_a, mac_b;
    t_mac_ctl                mac_ctl;
    logic signed [ACC_W-1:0] acc;

    logic [CW-1:0] cnt_m1;
    logic [AW-1:0] last_idx, nxt_i;
    logic          accept, store_ok;
    logic [4:0]    rel;
    logic [1:0]    m, idx;
    logic          near;
    logic signed [ACC_W-1:0] elen_sc;
    logic signed [OPW-1:0]   ph, pl;

    assign cnt_m1   = r_cnt - CW'(1);
    assign last_idx = cnt_m1[AW-1:0];
    assign nxt_i    = (r_i == last_idx) ? '0 : r_i + AW'(1);
    assign accept   = i_vtx.valid && i_vtx.ready;
    assign store_ok = (r_cnt < CW'(MAX_VERTICES));
    assign elen_sc  = ACC_W'(r_elen) <<< UNIT_SQ_SHIFT;
    assign ph       = OPW'(r_p >>> 27);
    assign pl       = OPW'({1'b0, r_p[26:0]});

    assign i_vtx.ready = (r_state == S_LOAD);
    assign o_res.valid = r_ovalid;
    assign o_res.data.hit    = r_ohit;
    assign o_res.data.status = r_ost;

    cpus_mac u_mac (
        .i_clk (i_clk),
        .i_a   (mac_a),
        .i_b   (mac_b),
        .i_ctl (mac_ctl),
        .o_acc (acc)
    );

    // Edge distance decision, valid in the last step of an edge pass.
    always_comb begin
        if (r_elen == '0 || r_ae > 0) begin
            near = (OPW'(r_aa) <= UNIT_SQ);
        end else if ((-r_ae) > r_elen) begin
            near = (OPW'(r_bb) <= UNIT_SQ);
        end else begin
            near = (acc <= elen_sc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_k      <= '0;
            r_i      <= '0;
            r_cnt    <= '0;
            r_ovr    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_i     <= n_i;
            if (accept) begin
                if (store_ok) begin
                    r_cnt <= r_cnt + CW'(1);
                end else begin
                    r_ovr <= 1'b1;
                end
            end
            if (emit_go) begin
                r_cnt    <= '0;
                r_ovr    <= 1'b0;
                r_ovalid <= 1'b1;
            end else if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // The output register keeps a waiting result steady while the next
    // polygon is loaded and tested.
    always_ff @(posedge i_clk) begin
        r_rhit <= n_rhit;
        r_rst  <= n_rst;
        if (emit_go) begin
            r_ohit <= r_rhit;
            r_ost  <= r_rst;
        end
    end

    // Vertex memory: one write port, two registered read ports.
    always_ff @(posedge i_clk) begin
        if (accept && store_ok) begin
            r_mem[r_cnt[AW-1:0]] <= {i_vtx.data.vertex_x, i_vtx.data.vertex_y,
                                     i_vtx.data.vertex_z};
        end
        if (rd_en) begin
            r_ra[0] <= r_mem[addr_a][47:32];
            r_ra[1] <= r_mem[addr_a][31:16];
            r_ra[2] <= r_mem[addr_a][15:0];
            r_rb[0] <= r_mem[addr_b][47:32];
            r_rb[1] <= r_mem[addr_b][31:16];
            r_rb[2] <= r_mem[addr_b][15:0];
        end
    end

    // Captures of read vertices, their differences and intermediate results from the accumulator.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_RD1: begin
                for (int c = 0; c < 3; c++) begin
                    r_v0[c] <= r_ra[c];
                    r_d1[c] <= 17'(r_rb[c]) - 17'(r_ra[c]);
                end
            end
            S_RD2: begin
                for (int c = 0; c < 3; c++) begin
                    r_d2[c] <= 17'(r_ra[c]) - 17'(r_v0[c]);
                end
            end
            S_NRM: begin
                if (r_k != '0 && !r_k[0]) begin
                    r_n[r_k[2:1] - 2'd1] <= acc[34:0];
                end
            end
            S_PLANE: begin
                if (r_k == 5'd3) begin
                    r_p <= acc[52:0];
                end
                if (r_k == 5'd6) begin
                    r_lim <= acc;
                end
            end
            S_ESUB: begin
                for (int c = 0; c < 3; c++) begin
                    r_e[c] <= 17'(r_rb[c]) - 17'(r_ra[c]);
                end
            end
            S_EDGE: begin
                if (r_k == 5'd3) begin
                    r_elen <= acc[OPW-1:0];
                end
                if (r_k == 5'd6) begin
                    r_aa <= acc[33:0];
                end
                if (r_k == 5'd9) begin
                    r_ae <= acc[OPW-1:0];
                end
                if (r_k == 5'd12) begin
                    r_bb <= acc[33:0];
                end
                if (r_k == 5'd14 || r_k == 5'd16 || r_k == 5'd18) begin
                    r_c[rel[2:1]] <= acc[33:0];
                end
            end
            S_WIND: begin
                if (r_k == 5'd2 || r_k == 5'd4 || r_k == 5'd6) begin
                    r_c[rel[2:1]] <= acc[33:0];
                end
            end
            default: begin
            end
        endcase
    end

    // Sequencer: next state, memory addresses and multiplier operands.
    always_comb begin
        n_state = r_state;
        n_k     = '0;
        n_i     = r_i;
        n_rhit  = r_rhit;
        n_rst   = r_rst;
        emit_go = 1'b0;
        rd_en   = 1'b0;
        addr_a  = r_i;
        addr_b  = nxt_i;
        mac_a   = '0;
        mac_b   = '0;
        mac_ctl = '{en: 1'b0, clr: 1'b0, neg: 1'b0, sh: SH_0};
        rel     = '0;
        m       = '0;
        idx     = '0;

        case (r_state)
            S_LOAD: begin
                if (accept && i_vtx.data.last_vertex) begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                n_rhit = 1'b0;
                if (r_ovr) begin
                    n_rst   = ST_TOOMANY;
                    n_state = S_EMIT;
                end else if (r_cnt < CW'(3)) begin
                    n_rst   = ST_DEGEN;
                    n_state = S_EMIT;
                end else begin
                    n_state = S_RD0;
                end
            end
            S_RD0: begin
                rd_en   = 1'b1;
                addr_a  = '0;
                addr_b  = AW'(1);
                n_state = S_RD1;
            end
            S_RD1: begin
                rd_en   = 1'b1;
                addr_a  = last_idx;
                n_state = S_RD2;
            end
            S_RD2: begin
                n_state = S_NRM;
            end
            S_NRM: begin
                // n = d1 x d2, two products per component.
                m = r_k[2:1];
                mac_ctl.en  = (r_k < 5'd6);
                mac_ctl.clr = !r_k[0];
                mac_ctl.neg = r_k[0];
                mac_a = r_k[0] ? OPW'(r_d1[nx(nx(m))]) : OPW'(r_d1[nx(m)]);
                mac_b = r_k[0] ? OPW'(r_d2[nx(m)]) : OPW'(r_d2[nx(nx(m))]);
                n_k = r_k + 5'd1;
                if (r_k == 5'd6) begin
                    n_k     = '0;
                    n_state = S_NZ;
                end
            end
            S_NZ: begin
                if (r_n[0] == '0 && r_n[1] == '0 && r_n[2] == '0) begin
                    n_rhit  = 1'b0;
                    n_rst   = ST_DEGEN;
                    n_state = S_EMIT;
                end else begin
                    n_state = S_PLANE;
                end
            end
            S_PLANE: begin
                // p = n.v0, then |n|^2 scaled, then p^2 from two halves of p.
                mac_ctl.en = (r_k < 5'd9);
                n_k = r_k + 5'd1;
                if (r_k < 5'd3) begin
                    idx = r_k[1:0];
                    mac_a = OPW'(r_n[idx]);
                    mac_b = OPW'(r_v0[idx]);
                    mac_ctl.clr = (r_k == 5'd0);
                end else if (r_k < 5'd6) begin
                    rel = r_k - 5'd3;
                    idx = rel[1:0];
                    mac_a = OPW'(r_n[idx]);
                    mac_b = OPW'(r_n[idx]);
                    mac_ctl.clr = (r_k == 5'd3);
                    mac_ctl.sh  = SH_24;
                end else if (r_k == 5'd6) begin
                    mac_a = ph;
                    mac_b = ph;
                    mac_ctl.clr = 1'b1;
                    mac_ctl.sh  = SH_54;
                end else if (r_k == 5'd7) begin
                    mac_a = ph;
                    mac_b = pl;
                    mac_ctl.sh = SH_28;
                end else if (r_k == 5'd8) begin
                    mac_a = pl;
                    mac_b = pl;
                end else begin
                    n_k = '0;
                    if (acc > r_lim) begin
                        n_rhit  = 1'b0;
                        n_rst   = ST_OK;
                        n_state = S_EMIT;
                    end else begin
                        n_i     = '0;
                        n_state = S_ERD;
                    end
                end
            end
            S_ERD: begin
                rd_en   = 1'b1;
                n_state = S_ESUB;
            end
            S_ESUB: begin
                n_state = S_EDGE;
            end
            S_EDGE: begin
                mac_ctl.en = (r_k < 5'd21);
                n_k = r_k + 5'd1;
                if (r_k < 5'd3) begin
                    idx = r_k[1:0];
                    mac_a = OPW'(r_e[idx]);
                    mac_b = OPW'(r_e[idx]);
                    mac_ctl.clr = (r_k == 5'd0);
                end else if (r_k < 5'd6) begin
                    rel = r_k - 5'd3;
                    idx = rel[1:0];
                    mac_a = OPW'(r_ra[idx]);
                    mac_b = OPW'(r_ra[idx]);
                    mac_ctl.clr = (r_k == 5'd3);
                end else if (r_k < 5'd9) begin
                    rel = r_k - 5'd6;
                    idx = rel[1:0];
                    mac_a = OPW'(r_ra[idx]);
                    mac_b = OPW'(r_e[idx]);
                    mac_ctl.clr = (r_k == 5'd6);
                end else if (r_k < 5'd12) begin
                    rel = r_k - 5'd9;
                    idx = rel[1:0];
                    mac_a = OPW'(r_rb[idx]);
                    mac_b = OPW'(r_rb[idx]);
                    mac_ctl.clr = (r_k == 5'd9);
                end else if (r_k < 5'd18) begin
                    // c = a x e
                    rel = r_k - 5'd12;
                    m = rel[2:1];
                    mac_ctl.clr = !rel[0];
                    mac_ctl.neg = rel[0];
                    mac_a = rel[0] ? OPW'(r_ra[nx(nx(m))]) : OPW'(r_ra[nx(m)]);
                    mac_b = rel[0] ? OPW'(r_e[nx(m)]) : OPW'(r_e[nx(nx(m))]);
                    if (r_k == 5'd14 || r_k == 5'd16) begin
                        rel = r_k - 5'd14;
                    end
                end else if (r_k < 5'd21) begin
                    rel = r_k - 5'd18;
                    idx = rel[1:0];
                    if (r_k == 5'd18) begin
                        rel = 5'd4;
                    end
                    mac_a = OPW'(r_c[idx]);
                    mac_b = OPW'(r_c[idx]);
                    mac_ctl.clr = (r_k == 5'd18);
                end else begin
                    n_k = '0;
                    if (near) begin
                        n_rhit  = 1'b1;
                        n_rst   = ST_OK;
                        n_state = S_EMIT;
                    end else if (r_i == last_idx) begin
                        n_i     = '0;
                        n_state = S_WRD;
                    end else begin
                        n_i     = nxt_i;
                        n_state = S_ERD;
                    end
                end
            end
            S_WRD: begin
                rd_en   = 1'b1;
                n_state = S_WIND;
            end
            S_WIND: begin
                // w = n . (vj x vi); a positive w puts the foot outside.
                mac_ctl.en = (r_k < 5'd9);
                n_k = r_k + 5'd1;
                if (r_k < 5'd6) begin
                    rel = r_k;
                    m = rel[2:1];
                    mac_ctl.clr = !rel[0];
                    mac_ctl.neg = rel[0];
                    mac_a = rel[0] ? OPW'(r_rb[nx(nx(m))]) : OPW'(r_rb[nx(m)]);
                    mac_b = rel[0] ? OPW'(r_ra[nx(m)]) : OPW'(r_ra[nx(nx(m))]);
                    if (r_k == 5'd2 || r_k == 5'd4) begin
                        rel = r_k - 5'd2;
                    end
                end else if (r_k < 5'd9) begin
                    rel = r_k - 5'd6;
                    idx = rel[1:0];
                    if (r_k == 5'd6) begin
                        rel = 5'd4;
                    end
                    mac_a = OPW'(r_n[idx]);
                    mac_b = OPW'(r_c[idx]);
                    mac_ctl.clr = (r_k == 5'd6);
                end else begin
                    n_k = '0;
                    if (acc > 0) begin
                        n_rhit  = 1'b0;
                        n_rst   = ST_OK;
                        n_state = S_EMIT;
                    end else if (r_i == last_idx) begin
                        n_rhit  = 1'b1;
                        n_rst   = ST_OK;
                        n_state = S_EMIT;
                    end else begin
                        n_i     = nxt_i;
                        n_state = S_WRD;
                    end
                end
            end
            S_EMIT: begin
                if (!r_ovalid || o_res.ready) begin
                    emit_go = 1'b1;
                    n_state = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    `CPUS_ASSERT_IMP(a_ovr_full, r_ovr, r_cnt == CW'(MAX_VERTICES))
    `CPUS_ASSERT_NXT(a_last_starts_test, accept && i_vtx.data.last_vertex, r_state == S_CHK)
    `CPUS_ASSERT_IMP(a_hit_only_ok, o_res.valid && o_res.data.hit, o_res.data.status == ST_OK)
    `CPUS_ASSERT_IMP(a_edge_in_range, r_state == S_EDGE, CW'(r_i) < r_cnt)
endmodule
`default_nettype wire

>>> sim/tb_convex_polygon_unit_sphere_test.sv
`timescale 1ns / 1ps
module tb_convex_polygon_unit_sphere_test;
    import cpus_pkg::*;

    localparam int NVMAX = 8;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    cpus_stream_if #(.T(t_vtx)) vtx_ch ();
    cpus_stream_if #(.T(t_res)) res_ch ();

    convex_polygon_unit_sphere_test #(.MAX_VERTICES(NVMAX)) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_vtx  (vtx_ch.sink),
        .o_res  (res_ch.source)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    typedef struct {
        logic signed [63:0] x, y, z;
    } vec_t;

    // Hold-off marker: the driver waits until every expected result is in.
    typedef struct {
        t_vtx v;
        bit   drain;
    } pend_t;

    pend_t pend_q[$];
    t_res  hit_q[$];
    vec_t  poly_store[NVMAX];
    int    poly_cnt = 0;
    bit    poly_over = 0;
    int    errors = 0;
    bit    quiet = 0;
    bit    stim_done = 0;

    function automatic vec_t vsub(vec_t a, vec_t b);
        vec_t r;
        r.x = a.x - b.x; r.y = a.y - b.y; r.z = a.z - b.z;
        return r;
    endfunction

    function automatic vec_t vcross(vec_t a, vec_t b);
        vec_t r;
        r.x = a.y * b.z - a.z * b.y;
        r.y = a.z * b.x - a.x * b.z;
        r.z = a.x * b.y - a.y * b.x;
        return r;
    endfunction

    function automatic logic signed [127:0] wdot(vec_t a, vec_t b);
        logic signed [127:0] ax, ay, az, bx, by, bz;
        ax = a.x; ay = a.y; az = a.z; bx = b.x; by = b.y; bz = b.z;
        return ax * bx + ay * by + az * bz;
    endfunction

    function automatic bit edge_near(vec_t a, vec_t b);
        vec_t e;
        logic signed [127:0] elen, q, lhs, rhs;
        e = vsub(b, a);
        elen = wdot(e, e);
        if (elen == 0) return wdot(a, a) <= 128'sd16777216;
        q = -wdot(a, e);
        if (q < 0) return wdot(a, a) <= 128'sd16777216;
        if (q > elen) return wdot(b, b) <= 128'sd16777216;
        lhs = wdot(vcross(a, e), vcross(a, e));
        rhs = elen * 128'sd16777216;
        return lhs <= rhs;
    endfunction

    function automatic bit sphere_hit(vec_t n);
        logic signed [127:0] p, nsq;
        int j;
        p = wdot(n, poly_store[0]);
        if (p < 0) p = -p;
        nsq = wdot(n, n);
        if (p * p > (nsq <<< 24)) return 0;
        for (int i = 0; i < poly_cnt; i++) begin
            j = (i + 1 == poly_cnt) ? 0 : i + 1;
            if (edge_near(poly_store[i], poly_store[j])) return 1;
        end
        for (int i = 0; i < poly_cnt; i++) begin
            j = (i + 1 == poly_cnt) ? 0 : i + 1;
            if (wdot(n, vcross(poly_store[j], poly_store[i])) > 0) return 0;
        end
        return 1;
    endfunction

    task automatic predict_vertex(t_vtx v);
        vec_t p, n;
        t_res r;
        p.x = v.vertex_x; p.y = v.vertex_y; p.z = v.vertex_z;
        if (poly_cnt < NVMAX) begin
            poly_store[poly_cnt] = p;
            poly_cnt++;
        end else begin
            poly_over = 1;
        end
        if (!v.last_vertex) return;
        r.hit = 1'b0;
        r.status = ST_OK;
        if (poly_over) begin
            r.status = ST_TOOMANY;
        end else if (poly_cnt < 3) begin
            r.status = ST_DEGEN;
        end else begin
            n = vcross(vsub(poly_store[1], poly_store[0]),
                       vsub(poly_store[poly_cnt-1], poly_store[0]));
            if (n.x == 0 && n.y == 0 && n.z == 0) r.status = ST_DEGEN;
            else r.hit = sphere_hit(n);
        end
        hit_q.push_back(r);
        poly_cnt = 0;
        poly_over = 0;
    endtask

    function automatic bit idle_now();
        return !quiet && ($urandom_range(99) < 31);
    endfunction

    // Driver.
    always @(posedge i_clk) begin
        pend_t nxt;
        if (!i_rst_n) begin
            vtx_ch.valid <= 1'b0;
            vtx_ch.data  <= '0;
        end else begin
            if (vtx_ch.valid && vtx_ch.ready) predict_vertex(vtx_ch.data);
            if (!vtx_ch.valid || vtx_ch.ready) begin
                if (pend_q.size() > 0 && pend_q[0].drain) begin
                    vtx_ch.valid <= 1'b0;
                    if (hit_q.size() == 0 && !(vtx_ch.valid && vtx_ch.ready))
                        void'(pend_q.pop_front());
                end else if (pend_q.size() > 0 && !idle_now()) begin
                    nxt = pend_q.pop_front();
                    vtx_ch.valid <= 1'b1;
                    vtx_ch.data  <= nxt.v;
                end else begin
                    vtx_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor.
    always @(posedge i_clk) begin
        t_res exp_r;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (hit_q.size() == 0) begin
                    $error("unexpected result hit=%0d status=%0d",
                           res_ch.data.hit, res_ch.data.status);
                    errors++;
                end else begin
                    exp_r = hit_q.pop_front();
                    if (res_ch.data.hit !== exp_r.hit) begin
                        $error("hit expected %0d actual %0d", exp_r.hit, res_ch.data.hit);
                        errors++;
                    end
                    if (res_ch.data.status !== exp_r.status) begin
                        $error("status expected %0d actual %0d",
                               exp_r.status, res_ch.data.status);
                        errors++;
                    end
                end
            end
            res_ch.ready <= !idle_now();
        end
    end

    task automatic add_vtx(int x, int y, int z, bit last);
        pend_t p;
        p.v.vertex_x = x; p.v.vertex_y = y; p.v.vertex_z = z;
        p.v.last_vertex = last;
        p.drain = 0;
        pend_q.push_back(p);
    endtask

    task automatic add_drain();
        pend_t p;
        p.v = '0;
        p.drain = 1;
        pend_q.push_back(p);
    endtask

    function automatic int clip(int v);
        return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
    endfunction

    // Polygon around a given center: a regular-ish fan in a random plane.
    task automatic add_polygon(int nv, int span, int cx, int cy, int cz);
        int ux, uy, uz, wx, wy, wz, ang;
        real c, s;
        ux = $urandom_range(2*span) - span; uy = $urandom_range(2*span) - span;
        uz = $urandom_range(2*span) - span;
        wx = $urandom_range(2*span) - span; wy = $urandom_range(2*span) - span;
        wz = $urandom_range(2*span) - span;
        for (int i = 0; i < nv; i++) begin
            ang = i;
            c = $cos(6.2831853 * ang / nv);
            s = $sin(6.2831853 * ang / nv);
            add_vtx(clip(cx + $rtoi(c*ux + s*wx)), clip(cy + $rtoi(c*uy + s*wy)),
                    clip(cz + $rtoi(c*uz + s*wz)), i == nv - 1);
        end
    endtask

    initial begin
        int nitems, k, sel, nv, span;
        vtx_ch.valid = 1'b0;
        vtx_ch.data = '0;
        res_ch.ready = 1'b0;
        // Directed: triangle through the sphere, far triangle, extremes,
        // degenerate, collinear, zero-length edge, overflow.
        add_vtx(-8192, -8192, 0, 0); add_vtx(8192, -8192, 0, 0);
        add_vtx(0, 8192, 0, 1);
        add_vtx(-8192, -8192, 20000, 0); add_vtx(8192, -8192, 20000, 0);
        add_vtx(0, 8192, 20000, 1);
        add_vtx(-32768, -32768, -32768, 0); add_vtx(32767, -32768, 32767, 0);
        add_vtx(32767, 32767, -32768, 1);
        add_vtx(100, 100, 100, 0); add_vtx(200, 0, 0, 1);
        add_vtx(5, 5, 5, 1);
        add_vtx(0, 0, 0, 0); add_vtx(4096, 4096, 4096, 0); add_vtx(8192, 8192, 8192, 1);
        add_vtx(4000, 0, 0, 0); add_vtx(4000, 0, 0, 0); add_vtx(0, 4000, 0, 1);
        for (int i = 0; i < 9; i++) add_vtx(i * 1000, i * i * 300, -i * 50, i == 8);
        add_drain();
        nitems = 27;
        k = 0;
        while (nitems < 1550) begin
            sel = $urandom_range(99);
            if (k == 40) add_drain();
            if (sel < 75) begin
                nv = $urandom_range(100) < 90 ? $urandom_range(6, 3) : $urandom_range(8, 7);
                span = $urandom_range(1) ? $urandom_range(6000, 500)
                                         : $urandom_range(30000, 1000);
                add_polygon(nv, span, $urandom_range(16000) - 8000,
                            $urandom_range(16000) - 8000, $urandom_range(16000) - 8000);
                nitems += nv;
            end else if (sel < 85) begin
                nv = $urandom_range(12, 1);
                for (int i = 0; i < nv; i++)
                    add_vtx($urandom_range(65535), $urandom_range(65535),
                            $urandom_range(65535), i == nv - 1);
                nitems += nv;
            end else if (sel < 92) begin
                nv = $urandom_range(2, 1);
                for (int i = 0; i < nv; i++)
                    add_vtx($urandom_range(65535), $urandom_range(65535),
                            $urandom_range(65535), i == nv - 1);
                nitems += nv;
            end else begin
                nv = $urandom_range(14, 9);
                add_polygon(nv, 5000, 0, 0, 1000);
                nitems += nv;
            end
            k++;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // Quiet stretch, with no random idles, while the queue drains from 1200 to 1000 items.
        wait (pend_q.size() < 1200);
        quiet = 1;
        wait (pend_q.size() < 1000);
        quiet = 0;
        wait (pend_q.size() == 0 && !vtx_ch.valid);
        wait (hit_q.size() == 0);
        repeat (400) @(posedge i_clk);
        if (errors == 0 && hit_q.size() == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end

    initial begin
        #20ms;
        $display("TB_ERROR");
        $finish;
    end
endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/cpus_pkg.sv
rtl/core/cpus_stream_if.sv
rtl/core/cpus_mac.sv
rtl/core/convex_polygon_unit_sphere_test.sv
sim/tb_convex_polygon_unit_sphere_test.sv
